FILE: sv/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam logic [OP_W-1:0] OP_WRITE_CHAR = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_ROW    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_COL    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } result_t;

endpackage

FILE: sv/tcc_ram.sv
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tcc_engine.sv
`timescale 1ns / 1ps

module tcc_engine
  import tcc_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic [ATTR_W-1:0] attr,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int SUM_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(CELLS - COLUMNS);
  localparam logic [SUM_W-1:0]  CELLS_EXT  = SUM_W'(CELLS);
  localparam logic [SUM_W-1:0]  COLS_EXT   = SUM_W'(COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_DRAIN,
    S_FILL,
    S_CLEAR,
    S_RESULT
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] cnt;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_addr;
  logic [CELL_W-1:0] value;
  logic              did_scroll;

  logic [SUM_W-1:0]  cur_lin;
  logic [SUM_W-1:0]  idx_ext;
  logic              accept;
  logic              idx_ok;
  logic              is_newline;
  logic [CELL_W-1:0] blank_cell;

  assign cur_lin    = SUM_W'(row) * COLS_EXT + SUM_W'(col);
  assign idx_ext    = SUM_W'(cell_index);
  assign idx_ok     = idx_ext < CELLS_EXT;
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_newline = (char_code == NEWLINE_CODE);
  assign blank_cell = {attr, SPACE_CODE};

  assign res_valid        = (state == S_RESULT);
  assign res.cursor_index = cur_lin[IDX_W-1:0];
  assign res.cell_value   = value;
  assign res.scrolled     = did_scroll;

  // single write port: cursor store, scroll copy, or blank fill
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = blank_cell;
    mem_raddr = cnt;
    case (state)
      S_IDLE: begin
        mem_raddr = idx_ext[ADDR_W-1:0];
        mem_waddr = cur_lin[ADDR_W-1:0];
        mem_wdata = {attr, char_code};
        mem_we    = accept && (operation == OP_WRITE_CHAR) && !is_newline;
      end
      S_COPY, S_DRAIN: begin
        mem_we    = copy_pend;
        mem_waddr = copy_addr;
        mem_wdata = mem_rdata;
      end
      S_FILL, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      copy_pend <= 1'b0;
    end else begin
      copy_pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            value      <= '0;
            did_scroll <= 1'b0;
            state      <= S_RESULT;
            case (operation)
              OP_WRITE_CHAR: begin
                if (is_newline || col == COL_LAST) begin
                  col <= '0;
                  if (row == ROW_LAST) begin
                    did_scroll <= 1'b1;
                    cnt        <= ROW_STRIDE;
                    state      <= S_COPY;
                  end else begin
                    row <= row + 1'b1;
                  end
                end else begin
                  col <= col + 1'b1;
                end
              end
              OP_CLEAR: begin
                row   <= '0;
                col   <= '0;
                cnt   <= '0;
                state <= S_CLEAR;
              end
              OP_SET_ROW: begin
                row <= (position > POS_W'(ROW_LAST)) ? ROW_LAST : position[ROW_W-1:0];
              end
              OP_SET_COL: begin
                col <= (position > POS_W'(COL_LAST)) ? COL_LAST : position[COL_W-1:0];
              end
              OP_READ_CELL: begin
                if (idx_ok) begin
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_READ: begin
          value <= mem_rdata;
          state <= S_RESULT;
        end
        // read one row ahead, write back in the following cycle
        S_COPY: begin
          copy_pend <= 1'b1;
          copy_addr <= cnt - ROW_STRIDE;
          if (cnt == CELL_LAST) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          cnt   <= FILL_START;
          state <= S_FILL;
        end
        S_FILL, S_CLEAR: begin
          if (cnt == CELL_LAST) begin
            state <= S_RESULT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/text_console_cursor_scroll_core.sv
`timescale 1ns / 1ps
// set, write and out-of-range read go from S_IDLE through S_RESULT to the output register;
// an in-range read also passes S_READ (registered cell memory read)
// clear and scroll (row copy, then blank fill of the last row) run one cell per cycle
// no new item is taken while one is in work
// reset: cursor at row 0 column 0, attribute 112, no result pending; cell memory undefined

module text_console_cursor_scroll_core
  import tcc_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  input  logic [IDX_W-1:0]  cell_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  cursor_index,
  output logic [CELL_W-1:0] cell_value,
  output logic              scrolled,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [ATTR_W-1:0] attr;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= 8'd112;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (res_ready) begin
        out_valid <= res_valid;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      cursor_index <= res.cursor_index;
      cell_value   <= res.cell_value;
      scrolled     <= res.scrolled;
    end
  end

  tcc_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .char_code  (char_code),
    .position   (position),
    .cell_index (cell_index),
    .attr       (attr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcc_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam int LAST_CELL = CELLS - 1;
  localparam int BOTTOM_ROW = (ROWS - 1) * COLS;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd112;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_READ_CELL + 3'd1;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 110;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRINT_CAP = 50;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  idx;
  } console_cmd_t;

  typedef struct {
    console_cmd_t cmd;
    bit           typed;
    result_t      want;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [POS_W-1:0]  position = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  cursor_index;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;

  // screen image and cursor as the block should hold them
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_row = 0;
  int                cur_col = 0;
  logic [ATTR_W-1:0] text_attr = RESET_ATTR;

  result_t           expected_results [$];
  directed_row_t     directed [$];
  int                mismatches = 0;
  int                results_seen = 0;
  int                quiet_cycles = 0;
  bit                sender_calm = 1'b0;

  text_console_cursor_scroll_core #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .char_code   (char_code),
    .position    (position),
    .cell_index  (cell_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cursor_index(cursor_index),
    .cell_value  (cell_value),
    .scrolled    (scrolled),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit advance_row();
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      cur_row = ROWS - 1;
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {text_attr, SPACE_CODE};
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic result_t console_step(input console_cmd_t c);
    result_t r;
    r = '0;
    case (c.op)
      OP_WRITE_CHAR: begin
        if (c.ch == NEWLINE_CODE) begin
          r.scrolled = advance_row();
        end else begin
          screen[cur_row * COLS + cur_col] = {text_attr, c.ch};
          cur_col++;
          if (cur_col >= COLS) r.scrolled = advance_row();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      OP_SET_ROW: cur_row = (c.pos > ROWS - 1) ? ROWS - 1 : int'(c.pos);
      OP_SET_COL: cur_col = (c.pos > COLS - 1) ? COLS - 1 : int'(c.pos);
      OP_READ_CELL: begin
        if (c.idx < CELLS) r.cell_value = screen[c.idx];
      end
      default: ;
    endcase
    r.cursor_index = IDX_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.op = OP_WRITE_CHAR;
    c.ch = CHAR_W'($urandom);
    c.pos = POS_W'($urandom);
    c.idx = IDX_W'($urandom);
    if (pick < 45) begin
      if ($urandom_range(0, 7) == 0) c.ch = NEWLINE_CODE;
    end else if (pick < 55) begin
      c.op = OP_SET_ROW;
      if (pick < 50) c.pos = POS_W'($urandom_range(ROWS - 3, ROWS - 1));
    end else if (pick < 63) begin
      c.op = OP_SET_COL;
      if (pick < 59) c.pos = POS_W'($urandom_range(COLS - 8, COLS - 1));
    end else if (pick < 87) begin
      c.op = OP_READ_CELL;
      if (pick < 83) c.idx = IDX_W'($urandom_range(0, CELLS - 1));
    end else if (pick < 90) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED_FIRST + OP_W'($urandom_range(0, 2));
    end
    return c;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                         input logic [POS_W-1:0] pos, input logic [IDX_W-1:0] idx,
                         input bit typed, input int cursor,
                         input logic [CELL_W-1:0] cell_want, input logic scr);
    directed_row_t row;
    row.cmd.op = op;
    row.cmd.ch = ch;
    row.cmd.pos = pos;
    row.cmd.idx = idx;
    row.typed = typed;
    row.want.cursor_index = IDX_W'(cursor);
    row.want.cell_value = cell_want;
    row.want.scrolled = scr;
    directed.push_back(row);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_cmd(input console_cmd_t c, input bit typed, input result_t want);
    int gap;
    result_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = c.op;
    char_code = c.ch;
    position = c.pos;
    cell_index = c.idx;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = console_step(c);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    text_attr = value;
  endtask

  initial begin : result_side
    result_t want;
    int hold;
    bit calm;
    bit held;
    calm = 1'b0;
    held = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      // long hold-off so the block backs up and stalls its input
      if (!held && results_seen >= HOLD_AT_RESULT) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      hold = calm ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, cursor %0d", cursor_index));
      end else begin
        want = expected_results.pop_front();
        if (cursor_index !== want.cursor_index)
          report_mismatch($sformatf("transfer %0d cursor_index got %0d want %0d",
                                    results_seen, cursor_index, want.cursor_index));
        if (cell_value !== want.cell_value)
          report_mismatch($sformatf("transfer %0d cell_value got %h want %h",
                                    results_seen, cell_value, want.cell_value));
        if (scrolled !== want.scrolled)
          report_mismatch($sformatf("transfer %0d scrolled got %b want %b",
                                    results_seen, scrolled, want.scrolled));
      end
      results_seen++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CELL_W-1:0] blank;
    logic [ATTR_W-1:0] attr;
    blank = {RESET_ATTR, SPACE_CODE};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cursor clamps, clear, reads of the cleared screen
    add_row(OP_SET_COL, 8'h00, 7'd127, 11'd0, 1'b1, COLS - 1, '0, 1'b0);
    add_row(OP_SET_ROW, 8'h00, 7'd127, 11'd0, 1'b1, LAST_CELL, '0, 1'b0);
    add_row(OP_CLEAR, 8'hff, 7'd127, 11'd2047, 1'b1, 0, '0, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, 11'd0, 1'b1, 0, blank, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, IDX_W'(LAST_CELL), 1'b1, 0, blank, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, 11'd2047, 1'b1, 0, '0, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, IDX_W'(CELLS), 1'b1, 0, '0, 1'b0);
    // character writes and readback
    add_row(OP_WRITE_CHAR, 8'h41, 7'd0, 11'd0, 1'b1, 1, '0, 1'b0);
    add_row(OP_WRITE_CHAR, 8'hff, 7'd127, 11'd2047, 1'b1, 2, '0, 1'b0);
    add_row(OP_WRITE_CHAR, 8'h00, 7'd0, 11'd0, 1'b1, 3, '0, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, 11'd0, 1'b1, 3, {RESET_ATTR, 8'h41}, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, 11'd1, 1'b0, 0, '0, 1'b0);
    add_row(OP_WRITE_CHAR, NEWLINE_CODE, 7'd0, 11'd0, 1'b1, COLS, '0, 1'b0);
    // unused operation codes
    add_row(OP_UNUSED_FIRST, 8'h00, 7'd0, 11'd0, 1'b1, COLS, '0, 1'b0);
    add_row(OP_UNUSED_FIRST + 3'd1, 8'h5a, 7'd42, 11'd5, 1'b1, COLS, '0, 1'b0);
    add_row(OP_UNUSED_FIRST + 3'd2, 8'hff, 7'd127, 11'd2047, 1'b1, COLS, '0, 1'b0);
    // wrap at row end, then scroll from the last cell
    add_row(OP_SET_COL, 8'h00, 7'(COLS - 1), 11'd0, 1'b1, 2 * COLS - 1, '0, 1'b0);
    add_row(OP_WRITE_CHAR, 8'h5a, 7'd0, 11'd0, 1'b1, 2 * COLS, '0, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, IDX_W'(2 * COLS - 1), 1'b1, 2 * COLS,
            {RESET_ATTR, 8'h5a}, 1'b0);
    add_row(OP_SET_ROW, 8'h00, 7'(ROWS - 1), 11'd0, 1'b1, BOTTOM_ROW, '0, 1'b0);
    add_row(OP_SET_COL, 8'h00, 7'(COLS - 1), 11'd0, 1'b1, LAST_CELL, '0, 1'b0);
    add_row(OP_WRITE_CHAR, 8'h71, 7'd0, 11'd0, 1'b1, BOTTOM_ROW, '0, 1'b1);
    add_row(OP_READ_CELL, 8'h00, 7'd0, IDX_W'(BOTTOM_ROW - 1), 1'b1, BOTTOM_ROW,
            {RESET_ATTR, 8'h71}, 1'b0);
    add_row(OP_READ_CELL, 8'h00, 7'd0, IDX_W'(COLS - 1), 1'b0, 0, '0, 1'b0);
    add_row(OP_WRITE_CHAR, NEWLINE_CODE, 7'd0, 11'd0, 1'b1, BOTTOM_ROW, '0, 1'b1);
    add_row(OP_SET_ROW, 8'h00, 7'd0, 11'd0, 1'b1, 0, '0, 1'b0);

    foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].typed, directed[i].want);

    for (int p = 0; p < PHASES; p++) begin
      in_valid = 1'b0;
      if (p == 0) attr = '0;
      else if (p == 1) attr = '1;
      else attr = ATTR_W'($urandom);
      write_attribute(attr);
      repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
    end
    in_valid = 1'b0;

    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
